[hw/rtl/fsx_pkg.sv]
// Package: shared types, constants and codes for the Forth stack execute unit.
package fsx_pkg;

   localparam int DataStackDepth   = 32;
   localparam int ReturnStackDepth = 32;
   localparam int MemoryWords      = 256;

   localparam int DsAw  = $clog2(DataStackDepth);
   localparam int RsAw  = $clog2(ReturnStackDepth);
   localparam int MemAw = $clog2(MemoryWords);
   localparam int DsCw  = $clog2(DataStackDepth + 1);
   localparam int RsCw  = $clog2(ReturnStackDepth + 1);

   typedef enum logic [4:0] {
      OP_PUSH = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3, OP_MOD = 5'd4,
      OP_EQ = 5'd5, OP_LT = 5'd6, OP_NOT = 5'd7, OP_DROP = 5'd8, OP_DUP = 5'd9,
      OP_SWAP = 5'd10, OP_OVER = 5'd11, OP_ROT = 5'd12, OP_MROT = 5'd13,
      OP_INC = 5'd14, OP_DEC = 5'd15, OP_STORE = 5'd16, OP_FETCH = 5'd17,
      OP_TOR = 5'd18, OP_RFROM = 5'd19, OP_RFETCH = 5'd20, OP_DOT = 5'd21,
      OP_EMIT = 5'd22
   } op_type;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_DUNDER   = 3'd1;
   localparam logic [2:0] ST_DOVER    = 3'd2;
   localparam logic [2:0] ST_RUNDER   = 3'd3;
   localparam logic [2:0] ST_ROVER    = 3'd4;
   localparam logic [2:0] ST_DIVZERO  = 3'd5;
   localparam logic [2:0] ST_BADADDR  = 3'd6;

   typedef struct packed {
      logic [4:0]  kind;
      logic signed [63:0] literal;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic signed [63:0] top_value;
      logic [5:0]  data_depth;
      logic        print_valid;
      logic signed [63:0] print_value;
      logic        print_is_char;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic start;    // latch request, begin operand reads
      logic rd2;      // operand read state; the datapath takes no action on it
      logic check;    // evaluate faults, launch arithmetic
      logic commit;   // write results and form response
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic need_rd2;
      logic arith_busy;
      logic mem_wait;
   } sts_type;

   typedef struct packed {
      logic [1:0] dpop;
      logic [1:0] dpush;
      logic       rpop;
      logic       rpush;
   } effect_type;

   function automatic effect_type op_effect(input logic [4:0] k);
      effect_type e;
      e = '0;
      case (k)
         OP_PUSH:   e = '{2'd0, 2'd1, 1'b0, 1'b0};
         OP_ADD, OP_SUB, OP_MUL, OP_MOD, OP_EQ, OP_LT:
                    e = '{2'd2, 2'd1, 1'b0, 1'b0};
         OP_NOT, OP_INC, OP_DEC, OP_FETCH:
                    e = '{2'd1, 2'd1, 1'b0, 1'b0};
         OP_DROP, OP_DOT, OP_EMIT:
                    e = '{2'd1, 2'd0, 1'b0, 1'b0};
         OP_DUP:    e = '{2'd1, 2'd2, 1'b0, 1'b0};
         OP_SWAP:   e = '{2'd2, 2'd2, 1'b0, 1'b0};
         OP_OVER:   e = '{2'd2, 2'd3, 1'b0, 1'b0};
         OP_ROT, OP_MROT:
                    e = '{2'd3, 2'd3, 1'b0, 1'b0};
         OP_STORE:  e = '{2'd2, 2'd0, 1'b0, 1'b0};
         OP_TOR:    e = '{2'd1, 2'd0, 1'b0, 1'b1};
         OP_RFROM:  e = '{2'd0, 2'd1, 1'b1, 1'b0};
         OP_RFETCH: e = '{2'd0, 2'd1, 1'b1, 1'b1};
         default:   e = '0;
      endcase
      return e;
   endfunction

endpackage

[hw/rtl/fsx_arith.sv]
// Iterative multiplier and truncated signed remainder unit, one bit per cycle.
module fsx_arith (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        is_mod,
   input  logic [63:0] y,
   input  logic [63:0] x,
   output logic        busy,
   output logic [63:0] result
);
   logic        busy_ff, busy_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        mod_ff, mod_in;
   logic        neg_ff, neg_in;
   logic [63:0] acc_ff, acc_in;    // product or partial remainder
   logic [63:0] a_ff, a_in;        // multiplicand or dividend bits
   logic [63:0] b_ff, b_in;        // multiplier or divisor magnitude
   logic [64:0] trial;
   logic [63:0] shifted;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      mod_in  = mod_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      shifted = {acc_ff[62:0], a_ff[63]};
      trial   = {1'b0, shifted} - {1'b0, b_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 7'd0;
         mod_in  = is_mod;
         acc_in  = '0;
         if (is_mod) begin
            neg_in = y[63];
            a_in   = y[63] ? (64'd0 - y) : y;
            b_in   = x[63] ? (64'd0 - x) : x;
         end else begin
            neg_in = 1'b0;
            a_in   = y;
            b_in   = x;
         end
      end else if (busy_ff) begin
         if (mod_ff) begin
            acc_in = trial[64] ? shifted : trial[63:0];
            a_in   = {a_ff[62:0], 1'b0};
         end else begin
            acc_in = acc_ff + (b_ff[0] ? a_ff : 64'd0);
            a_in   = {a_ff[62:0], 1'b0};
            b_in   = {1'b0, b_ff[63:1]};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      mod_ff <= mod_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign busy   = busy_ff;
   assign result = (mod_ff && neg_ff) ? (64'd0 - acc_ff) : acc_ff;
endmodule

[hw/rtl/fsx_ctrl.sv]
// Controller state machine sequencing one primitive per request beat.
module fsx_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  fsx_pkg::sts_type  sts,
   output fsx_pkg::cmd_type  cmd
);
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_CHECK = 5'b00100,
      S_EXEC  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            // Read data of all operands is now registered.
            cmd.rd2  = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            if (!sts.arith_busy && !sts.mem_wait) begin
               cmd.commit = 1'b1;
               state_in   = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule

[hw/rtl/fsx_datapath.sv]
// Datapath: stack memories, data memory, operand registers and result logic.
module fsx_datapath (
   input  logic              clock,
   input  logic              reset,
   input  fsx_pkg::req_type  req,
   input  fsx_pkg::cmd_type  cmd,
   output fsx_pkg::sts_type  sts,
   output fsx_pkg::rsp_type  rsp
);
   localparam int DsAw  = fsx_pkg::DsAw;
   localparam int RsAw  = fsx_pkg::RsAw;
   localparam int MemAw = fsx_pkg::MemAw;
   localparam int DsCw  = fsx_pkg::DsCw;
   localparam int RsCw  = fsx_pkg::RsCw;

   logic [63:0] ds_mem [fsx_pkg::DataStackDepth];
   logic [63:0] rs_mem [fsx_pkg::ReturnStackDepth];
   logic [63:0] dmem   [fsx_pkg::MemoryWords];

   // Data memory reads zero until an entry is written.
   logic [fsx_pkg::MemoryWords-1:0] dvalid_ff;

   logic [DsCw-1:0] dn_ff;
   logic [RsCw-1:0] rn_ff;
   logic [4:0]      kind_ff;
   logic [63:0]     lit_ff;
   fsx_pkg::effect_type eff;

   logic [63:0] x_ff, y_ff, z_ff, r_ff, top_ff;
   logic [63:0] w_ff;  // fourth entry from the top, for pops of three
   logic [63:0] dsw_q;
   logic [2:0]  status_ff;
   logic        ok_ff;
   logic [63:0] mrd_ff;
   logic        mvalid_ff;
   logic        mem_wait_ff;
   fsx_pkg::rsp_type rsp_ff;

   logic        arith_busy;
   logic [63:0] arith_res;

   assign eff = fsx_pkg::op_effect(kind_ff);

   // Read ports: x, y, z and the return top are registered reads at the current depth.
   logic [DsAw-1:0] ra_x, ra_y, ra_z;
   logic [RsAw-1:0] ra_r;
   assign ra_x = DsAw'(dn_ff - DsCw'(1));
   assign ra_y = DsAw'(dn_ff - DsCw'(2));
   assign ra_z = DsAw'(dn_ff - DsCw'(3));
   assign ra_r = RsAw'(rn_ff - RsCw'(1));

   logic [63:0] dsx_q, dsy_q, dsz_q, rs_q;
   always_ff @(posedge clock) begin
      dsx_q <= ds_mem[ra_x];
      dsy_q <= ds_mem[ra_y];
      dsz_q <= ds_mem[ra_z];
      rs_q  <= rs_mem[ra_r];
   end

   // Fault checks.
   logic [2:0] st_c;
   logic [DsCw+1:0] dnext;
   logic [RsCw:0]   rnext;
   always_comb begin
      dnext = (DsCw+2)'(dn_ff) - (DsCw+2)'(eff.dpop) + (DsCw+2)'(eff.dpush);
      rnext = (RsCw+1)'(rn_ff) - (RsCw+1)'(eff.rpop) + (RsCw+1)'(eff.rpush);
      st_c = fsx_pkg::ST_OK;
      if (kind_ff > 5'd22)                            st_c = fsx_pkg::ST_OK;
      else if (dn_ff < DsCw'(eff.dpop))               st_c = fsx_pkg::ST_DUNDER;
      else if (dnext > (DsCw+2)'(fsx_pkg::DataStackDepth)) st_c = fsx_pkg::ST_DOVER;
      else if (rn_ff < RsCw'(eff.rpop))               st_c = fsx_pkg::ST_RUNDER;
      else if (rnext > (RsCw+1)'(fsx_pkg::ReturnStackDepth)) st_c = fsx_pkg::ST_ROVER;
      else if (kind_ff == fsx_pkg::OP_MOD && dsx_q == 64'd0) st_c = fsx_pkg::ST_DIVZERO;
      else if ((kind_ff == fsx_pkg::OP_STORE || kind_ff == fsx_pkg::OP_FETCH) &&
               dsx_q >= 64'(fsx_pkg::MemoryWords))    st_c = fsx_pkg::ST_BADADDR;
   end

   fsx_arith u_arith (
      .clock (clock),
      .reset (reset),
      .start (cmd.check && st_c == fsx_pkg::ST_OK && kind_ff <= 5'd22 &&
              (kind_ff == fsx_pkg::OP_MUL ||
               (kind_ff == fsx_pkg::OP_MOD && dsx_q != 64'hFFFF_FFFF_FFFF_FFFF))),
      .is_mod(kind_ff == fsx_pkg::OP_MOD),
      .y     (dsy_q),
      .x     (dsx_q),
      .busy  (arith_busy),
      .result(arith_res)
   );

   assign sts.need_rd2   = 1'b0;
   assign sts.arith_busy = arith_busy;
   assign sts.mem_wait   = mem_wait_ff;

   // Result words.
   logic [63:0] res0, res1, res2, r0_alu;
   logic        pv, pc;
   logic [63:0] pval;
   logic [63:0] fetch_val;
   logic signed [63:0] sy, sx;
   assign sy = signed'(y_ff);
   assign sx = signed'(x_ff);
   assign fetch_val = mvalid_ff ? mrd_ff : 64'd0;

   always_comb begin
      res0 = '0; res1 = '0; res2 = '0; pv = 1'b0; pc = 1'b0; pval = '0;
      case (kind_ff)
         fsx_pkg::OP_PUSH:  res0 = lit_ff;
         fsx_pkg::OP_ADD:   res0 = y_ff + x_ff;
         fsx_pkg::OP_SUB:   res0 = y_ff - x_ff;
         fsx_pkg::OP_MUL:   res0 = arith_res;
         fsx_pkg::OP_MOD:   res0 = (x_ff == 64'hFFFF_FFFF_FFFF_FFFF) ? 64'd0 : arith_res;
         fsx_pkg::OP_EQ:    res0 = {63'd0, y_ff == x_ff};
         fsx_pkg::OP_LT:    res0 = {63'd0, sy < sx};
         fsx_pkg::OP_NOT:   res0 = {63'd0, x_ff == 64'd0};
         fsx_pkg::OP_DUP:   begin res0 = x_ff; res1 = x_ff; end
         fsx_pkg::OP_SWAP:  begin res0 = x_ff; res1 = y_ff; end
         fsx_pkg::OP_OVER:  begin res0 = y_ff; res1 = x_ff; res2 = y_ff; end
         fsx_pkg::OP_ROT:   begin res0 = y_ff; res1 = x_ff; res2 = z_ff; end
         fsx_pkg::OP_MROT:  begin res0 = x_ff; res1 = z_ff; res2 = y_ff; end
         fsx_pkg::OP_INC:   res0 = x_ff + 64'd1;
         fsx_pkg::OP_DEC:   res0 = x_ff - 64'd1;
         fsx_pkg::OP_FETCH: res0 = fetch_val;
         fsx_pkg::OP_RFROM, fsx_pkg::OP_RFETCH: res0 = r_ff;
         fsx_pkg::OP_DOT:   begin pv = 1'b1; pval = x_ff; end
         fsx_pkg::OP_EMIT:  begin pv = 1'b1; pc = 1'b1; pval = {56'd0, x_ff[7:0]}; end
         default: ;
      endcase
   end

   // New top after the step: the last pushed word, or the entry now on top.
   logic [DsCw-1:0] base;
   logic [DsCw-1:0] dn_new;
   logic [63:0]     top_new;
   logic [63:0]     below;   // word under the popped region
   always_comb begin
      base   = dn_ff - DsCw'(eff.dpop);
      dn_new = base + DsCw'(eff.dpush);
      // After popping k words the entry at base-1 is one of the read operands.
      case (eff.dpop)
         2'd0: below = top_ff;
         2'd1: below = y_ff;
         2'd2: below = z_ff;
         default: below = w_ff;
      endcase
      case (eff.dpush)
         2'd1: top_new = res0;
         2'd2: top_new = res1;
         2'd3: top_new = res2;
         default: top_new = (base == '0) ? 64'd0 : below;
      endcase
   end

   always_ff @(posedge clock) dsw_q <= ds_mem[DsAw'(dn_ff - DsCw'(4))];

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         kind_ff <= req.kind;
         lit_ff  <= req.literal;
      end
      if (cmd.rd2) begin
         // The registered reads now hold x, y, z, w and rtop.
      end
      if (cmd.check) begin
         x_ff      <= dsx_q;
         y_ff      <= (dn_ff >= DsCw'(2)) ? dsy_q : 64'd0;
         z_ff      <= (dn_ff >= DsCw'(3)) ? dsz_q : 64'd0;
         w_ff      <= (dn_ff >= DsCw'(4)) ? dsw_q : 64'd0;
         r_ff      <= rs_q;
         status_ff <= st_c;
         ok_ff     <= (st_c == fsx_pkg::ST_OK) && (kind_ff <= 5'd22);
         mrd_ff    <= dmem[MemAw'(dsx_q)];
         mvalid_ff <= dvalid_ff[MemAw'(dsx_q)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) mem_wait_ff <= 1'b0;
      else       mem_wait_ff <= cmd.check;
   end

   // Stack writes at commit, one write port per pushed slot.
   always_ff @(posedge clock) begin
      if (cmd.commit && ok_ff) begin
         if (eff.dpush >= 2'd1) ds_mem[DsAw'(base)]            <= res0;
         if (eff.dpush >= 2'd2) ds_mem[DsAw'(base + DsCw'(1))] <= res1;
         if (eff.dpush == 2'd3) ds_mem[DsAw'(base + DsCw'(2))] <= res2;
         if (kind_ff == fsx_pkg::OP_TOR) rs_mem[RsAw'(rn_ff)] <= x_ff;
         if (kind_ff == fsx_pkg::OP_STORE) dmem[MemAw'(x_ff)] <= y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dn_ff     <= '0;
         rn_ff     <= '0;
         dvalid_ff <= '0;
         top_ff    <= '0;
      end else if (cmd.commit && ok_ff) begin
         dn_ff  <= dn_new;
         rn_ff  <= rn_ff - RsCw'(eff.rpop) + RsCw'(eff.rpush);
         top_ff <= top_new;
         if (kind_ff == fsx_pkg::OP_STORE) dvalid_ff[MemAw'(x_ff)] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.status        <= status_ff;
         rsp_ff.top_value     <= ok_ff ? top_new : top_ff;
         rsp_ff.data_depth    <= 6'(ok_ff ? dn_new : dn_ff);
         rsp_ff.print_valid   <= ok_ff & pv;
         rsp_ff.print_value   <= ok_ff ? pval : 64'd0;
         rsp_ff.print_is_char <= ok_ff & pc;
      end
   end

   assign rsp = rsp_ff;
endmodule

[hw/rtl/forth_stack_execute_unit_top.sv]
// Top level of the Forth stack execute unit.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    fsx_pkg::req_type (kind, literal)
//   rsp_      out        rsp_valid/rsp_ready    fsx_pkg::rsp_type (status .. print_is_char)
//
// Each request beat passes through accept, operand read, fault check, execute and
// response states, plus response wait. Multiply and modulo run on a bit-serial
// unit that holds the execute state while busy. The stack and data memories are
// single arrays read through registered ports. Reset empties both stacks and
// marks every data memory word as zero.
// A stalled response holds the unit; no new beat is taken until it leaves.
module forth_stack_execute_unit_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fsx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fsx_pkg::rsp_type rsp_data
);
   fsx_pkg::cmd_type cmd;
   fsx_pkg::sts_type sts;

   // The controller decides when each step of a primitive happens.
   fsx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds all stack and memory state.
   fsx_datapath u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_data),
      .cmd   (cmd),
      .sts   (sts),
      .rsp   (rsp_data)
   );
endmodule

[hw/rtl/fsx_checker.sv]
// Port checker for the Forth stack execute unit, bound to the top level.
module fsx_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input fsx_pkg::rsp_type rsp_data
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");
   a_no_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("response too early");
   a_print_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.print_valid |-> rsp_data.status == fsx_pkg::ST_OK)
      else $error("print on error");
   a_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.data_depth <= 6'd32) else $error("depth out of range");
endmodule

bind forth_stack_execute_unit_top fsx_checker u_fsx_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
